// ===== rtl/rpc_frame_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// rpc_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules. The including module
// supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef RPC_FRAME_DEFRAMER_ASSERT_SVH
`define RPC_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpc_frame_deframer: assertion failed");

// Next-cycle implication, checked outside reset
`define RFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpc_frame_deframer: assertion failed");

`endif

// ===== rtl/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// Types and constants of the RPC frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int unsigned LEN_WIDTH_DEF  = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned HDR_BYTES      = 4;
  // start and end bytes plus six 32-bit header fields
  localparam int unsigned FIXED_OVERHEAD = 2 + 24;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_STRING_LEN = 2'd2;

  localparam logic [7:0]  START_BYTE_RST     = 8'd2;
  localparam logic [7:0]  END_BYTE_RST       = 8'd3;
  localparam logic [15:0] MAX_STRING_LEN_RST = 16'd512;

  typedef enum logic [3:0] {
    PH_START       = 4'd0,
    PH_TOTAL_LEN   = 4'd1,
    PH_ID_LEN      = 4'd2,
    PH_ID          = 4'd3,
    PH_METHOD_LEN  = 4'd4,
    PH_METHOD      = 4'd5,
    PH_ERR_CODE    = 4'd6,
    PH_INFO_LEN    = 4'd7,
    PH_INFO        = 4'd8,
    PH_PAYLOAD     = 4'd9,
    PH_CHECKSUM    = 4'd10,
    PH_END         = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_START  = 3'd1,
    ST_BAD_END   = 3'd2,
    ST_PAST_END  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
    logic       is_start;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    phase_t               field_kind;
    logic [7:0]           out_byte;
    logic [VALUE_W-1:0]   field_value;
    logic                 value_valid;
    logic                 frame_done;
    status_t              status;
  } result_t;

endpackage

// ===== rtl/rfd_front.sv =====
// ----------------------------------------------------------------------------
// rfd_front
// Input side: tags each word against the start and end bytes and holds it
// in a two-slot queue until the core takes it.
// ----------------------------------------------------------------------------
module rfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        data_byte,
  input  logic              buffer_end,
  input  logic [7:0]        start_byte,
  input  logic [7:0]        end_byte,
  output rfd_pkg::in_word_t head,
  output logic              avail,
  input  logic              take
);
  import rfd_pkg::*;

  in_word_t word_in;
  in_word_t slot0;
  in_word_t slot1;
  logic     v0;
  logic     v1;
  logic     do_push;
  logic     do_pop;

  always_comb begin
    word_in.data_byte  = data_byte;
    word_in.buffer_end = buffer_end;
    word_in.is_start   = (data_byte == start_byte);
    word_in.is_end     = (data_byte == end_byte);
  end

  assign full    = v1;
  assign avail   = v0;
  assign head    = slot0;
  assign do_push = push && !v1;
  assign do_pop  = take && v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (do_pop && !do_push) begin
      v0 <= v1;
      v1 <= 1'b0;
    end else if (do_push && !do_pop) begin
      if (v0) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && do_push) begin
      if (v1) begin
        slot0 <= slot1;
        slot1 <= word_in;
      end else begin
        slot0 <= word_in;
      end
    end else if (do_pop) begin
      slot0 <= slot1;
    end else if (do_push) begin
      if (v0) begin
        slot1 <= word_in;
      end else begin
        slot0 <= word_in;
      end
    end
  end

endmodule

// ===== rtl/rfd_core.sv =====
// ----------------------------------------------------------------------------
// rfd_core
// Frame walker: one word a cycle while a word waits and the result queue is
// not full; tracks field, position and remaining room, assembles 32-bit
// fields and flags framing errors.
`include "rpc_frame_deframer_assert.svh"

module rfd_core #(
  parameter int unsigned LEN_WIDTH = rfd_pkg::LEN_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rfd_pkg::in_word_t word,
  input  logic              in_avail,
  output logic              in_take,
  input  logic [15:0]       max_string_len,
  output rfd_pkg::result_t  res,
  output logic              res_push,
  input  logic              out_full
);
  import rfd_pkg::*;

  // room = total length minus overhead and strings seen; goes negative
  localparam int unsigned RW = LEN_WIDTH + 3;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [LEN_WIDTH-1:0]   frame_pos;
  logic [LEN_WIDTH-1:0]   frame_pos_next;
  logic [LEN_WIDTH-1:0]   field_left;
  logic [LEN_WIDTH-1:0]   field_left_next;
  logic [LEN_WIDTH-1:0]   total_len;
  logic [LEN_WIDTH-1:0]   total_len_next;
  logic [VALUE_W-1:0]     value_shift;
  logic [VALUE_W-1:0]     value_shift_next;
  logic signed [RW-1:0]   room;
  logic signed [RW-1:0]   room_next;
  logic signed [RW-1:0]   room_sub;
  logic [VALUE_W-1:0]     shifted;
  logic [LEN_WIDTH:0]     pos_inc;
  logic                   step;
  logic                   header;
  logic                   field_end;
  logic                   past_end;
  logic                   too_long;
  logic                   len_over;
  status_t                st;

  assign step     = in_avail && !out_full;
  assign in_take  = step;
  assign res_push = step;

  assign shifted   = {value_shift[VALUE_W-9:0], word.data_byte};
  assign pos_inc   = {1'b0, frame_pos} + {{LEN_WIDTH{1'b0}}, 1'b1};
  assign past_end  = pos_inc >= {1'b0, total_len};
  assign too_long  = shifted > {{(VALUE_W-16){1'b0}}, max_string_len};
  assign len_over  = (shifted >> LEN_WIDTH) != '0;
  assign field_end = (field_left[LEN_WIDTH-1:1] == '0);
  assign room_sub  = room - $signed({{(RW-16){1'b0}}, shifted[15:0]});

  always_comb begin
    header = (phase == PH_TOTAL_LEN) || (phase == PH_ID_LEN) ||
             (phase == PH_METHOD_LEN) || (phase == PH_ERR_CODE) ||
             (phase == PH_INFO_LEN) || (phase == PH_CHECKSUM);
  end

  always_comb begin
    phase_next       = phase;
    frame_pos_next   = frame_pos;
    field_left_next  = field_left;
    total_len_next   = total_len;
    value_shift_next = value_shift;
    room_next        = room;
    st               = ST_OK;

    res.field_kind  = phase;
    res.out_byte    = word.data_byte;
    res.field_value = '0;
    res.value_valid = 1'b0;
    res.frame_done  = 1'b0;

    if (phase == PH_START) begin
      res.frame_done = 1'b1;
      if (!word.is_start) begin
        st = ST_NO_START;
      end else if (word.buffer_end) begin
        st = ST_BAD_END;
      end else begin
        res.frame_done   = 1'b0;
        frame_pos_next   = LEN_WIDTH'(1);
        phase_next       = PH_TOTAL_LEN;
        field_left_next  = LEN_WIDTH'(HDR_BYTES);
        value_shift_next = '0;
      end
    end else if (phase == PH_END) begin
      res.frame_done = 1'b1;
      st = (word.is_end && word.buffer_end) ? ST_OK : ST_BAD_END;
    end else if (word.buffer_end) begin
      st = ST_BAD_END;
    end else if (phase != PH_TOTAL_LEN && past_end) begin
      st = ST_PAST_END;
    end else begin
      if (header) begin
        value_shift_next = shifted;
      end
      if (field_left != '0) begin
        field_left_next = field_left - LEN_WIDTH'(1);
      end
      frame_pos_next = pos_inc[LEN_WIDTH-1:0];
      if (field_end) begin
        if (header) begin
          res.value_valid = 1'b1;
          res.field_value = shifted;
        end
        // every field change below also clears the shift register
        value_shift_next = '0;
        unique case (phase)
          PH_TOTAL_LEN: begin
            total_len_next = shifted[LEN_WIDTH-1:0];
            room_next      = $signed({3'b000, shifted[LEN_WIDTH-1:0]}) -
                             $signed(RW'(FIXED_OVERHEAD));
            if (len_over) begin
              st = ST_PAST_END;
            end else begin
              phase_next      = PH_ID_LEN;
              field_left_next = LEN_WIDTH'(HDR_BYTES);
            end
          end
          PH_ID_LEN, PH_METHOD_LEN: begin
            if (too_long) begin
              st = ST_TOO_LONG;
            end else begin
              room_next = room_sub;
              if (shifted != '0) begin
                phase_next      = (phase == PH_ID_LEN) ? PH_ID : PH_METHOD;
                field_left_next = shifted[LEN_WIDTH-1:0];
              end else begin
                phase_next      = (phase == PH_ID_LEN) ? PH_METHOD_LEN : PH_ERR_CODE;
                field_left_next = LEN_WIDTH'(HDR_BYTES);
              end
            end
          end
          PH_ID: begin
            phase_next      = PH_METHOD_LEN;
            field_left_next = LEN_WIDTH'(HDR_BYTES);
          end
          PH_METHOD: begin
            phase_next      = PH_ERR_CODE;
            field_left_next = LEN_WIDTH'(HDR_BYTES);
          end
          PH_ERR_CODE: begin
            phase_next      = PH_INFO_LEN;
            field_left_next = LEN_WIDTH'(HDR_BYTES);
          end
          PH_INFO_LEN: begin
            if (too_long) begin
              st = ST_TOO_LONG;
            end else if (room_sub < 0) begin
              st = ST_PAST_END;
            end else begin
              room_next = room_sub;
              if (shifted != '0) begin
                phase_next      = PH_INFO;
                field_left_next = shifted[LEN_WIDTH-1:0];
              end else if (room_sub != '0) begin
                phase_next      = PH_PAYLOAD;
                field_left_next = room_sub[LEN_WIDTH-1:0];
              end else begin
                phase_next      = PH_CHECKSUM;
                field_left_next = LEN_WIDTH'(HDR_BYTES);
              end
            end
          end
          PH_INFO: begin
            if (room != '0) begin
              phase_next      = PH_PAYLOAD;
              field_left_next = room[LEN_WIDTH-1:0];
            end else begin
              phase_next      = PH_CHECKSUM;
              field_left_next = LEN_WIDTH'(HDR_BYTES);
            end
          end
          PH_PAYLOAD: begin
            phase_next      = PH_CHECKSUM;
            field_left_next = LEN_WIDTH'(HDR_BYTES);
          end
          default: begin
            phase_next      = PH_END;
            field_left_next = '0;
          end
        endcase
      end
    end

    // any error closes the frame; rearm for a start byte
    if (st != ST_OK) begin
      res.frame_done = 1'b1;
    end
    if (res.frame_done) begin
      phase_next       = PH_START;
      frame_pos_next   = '0;
      field_left_next  = '0;
      value_shift_next = '0;
    end
    res.status = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      frame_pos   <= '0;
      field_left  <= '0;
      value_shift <= '0;
    end else if (step) begin
      phase       <= phase_next;
      frame_pos   <= frame_pos_next;
      field_left  <= field_left_next;
      value_shift <= value_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      total_len <= total_len_next;
      room      <= room_next;
    end
  end

  `RFD_ASSERT_NEXT(a_done_rearms, step && res.frame_done, phase == PH_START)
  `RFD_ASSERT_IMPL(a_idle_counters_clear, phase == PH_START, frame_pos == '0 && field_left == '0)
  `RFD_ASSERT_IMPL(a_value_on_header, step && res.value_valid, header)

endmodule

// ===== rtl/rfd_outq.sv =====
// ----------------------------------------------------------------------------
// rfd_outq
// Result side: two-slot queue between the core and the consumer, so the
// core keeps running while a finished word waits to be popped.
// ----------------------------------------------------------------------------
`include "rpc_frame_deframer_assert.svh"

module rfd_outq (
  input  logic             clk,
  input  logic             rst,
  input  rfd_pkg::result_t word_in,
  input  logic             push,
  output logic             full,
  output rfd_pkg::result_t head,
  output logic             empty,
  input  logic             pop
);
  import rfd_pkg::*;

  result_t slot0;
  result_t slot1;
  logic    v0;
  logic    v1;
  logic    do_push;
  logic    do_pop;

  assign full    = v1;
  assign empty   = !v0;
  assign head    = slot0;
  assign do_push = push && !v1;
  assign do_pop  = pop && v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (do_pop && !do_push) begin
      v0 <= v1;
      v1 <= 1'b0;
    end else if (do_push && !do_pop) begin
      if (v0) begin
        v1 <= 1'b1;
      end else begin
        v0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && do_push) begin
      if (v1) begin
        slot0 <= slot1;
        slot1 <= word_in;
      end else begin
        slot0 <= word_in;
      end
    end else if (do_pop) begin
      slot0 <= slot1;
    end else if (do_push) begin
      if (v0) begin
        slot1 <= word_in;
      end else begin
        slot0 <= word_in;
      end
    end
  end

  `RFD_ASSERT_IMPL(a_no_push_when_full, push, !v1)
  `RFD_ASSERT_IMPL(a_second_slot_needs_first, v1, v0)

endmodule

// ===== rtl/rpc_frame_deframer.sv =====
// Path: a pushed word is registered in the input queue, passes through the
// combinational core and is registered in the output queue for popping.
// Throughput: one word per cycle while the consumer keeps popping.
// Reset (rst, synchronous): queues empty, walker waits for a start byte,
// registers return to start 2, end 3, string limit 512.
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// Byte-serial deframer for a length-prefixed RPC frame: tags every word with
// its field, assembles 32-bit fields and reports framing errors.
// ----------------------------------------------------------------------------
module rpc_frame_deframer #(
  parameter int unsigned LEN_WIDTH = rfd_pkg::LEN_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      data_byte,
  input  logic                            buffer_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [3:0]                      field_kind,
  output logic [7:0]                      out_byte,
  output logic [31:0]                     field_value,
  output logic                            value_valid,
  output logic                            frame_done,
  output logic [2:0]                      status,
  input  logic                            cfg_we,
  input  logic [rfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rfd_pkg::*;

  logic [7:0]  start_byte;
  logic [7:0]  end_byte;
  logic [15:0] max_string_len;

  in_word_t    head_in;
  logic        in_avail;
  logic        in_take;
  result_t     res;
  logic        res_push;
  logic        out_full;
  result_t     head_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RST;
      end_byte       <= END_BYTE_RST;
      max_string_len <= MAX_STRING_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:     start_byte     <= cfg_data[7:0];
        REG_END_BYTE:       end_byte       <= cfg_data[7:0];
        REG_MAX_STRING_LEN: max_string_len <= cfg_data[15:0];
        default: ; // hold
      endcase
    end
  end

  rfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .buffer_end (buffer_end),
    .start_byte (start_byte),
    .end_byte   (end_byte),
    .head       (head_in),
    .avail      (in_avail),
    .take       (in_take)
  );

  rfd_core #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .word           (head_in),
    .in_avail       (in_avail),
    .in_take        (in_take),
    .max_string_len (max_string_len),
    .res            (res),
    .res_push       (res_push),
    .out_full       (out_full)
  );

  rfd_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .word_in (res),
    .push    (res_push),
    .full    (out_full),
    .head    (head_out),
    .empty   (empty),
    .pop     (pop)
  );

  assign field_kind  = head_out.field_kind;
  assign out_byte    = head_out.out_byte;
  assign field_value = head_out.field_value;
  assign value_valid = head_out.value_valid;
  assign frame_done  = head_out.frame_done;
  assign status      = head_out.status;

endmodule
